FILE: hdl/projection_ratio_stats_core_defines.svh
// Assertion macros shared by the projection ratio statistics design.
`ifndef PROJECTION_RATIO_STATS_CORE_DEFINES_SVH
`define PROJECTION_RATIO_STATS_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PRS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("prs assertion failed");

// Next-cycle implication, checked outside reset.
`define PRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("prs assertion failed");

`endif

FILE: hdl/prs_pkg.sv
// Package with shared constants, codes, state type and control structs.
package prs_pkg;

    localparam int VEC_MAX_DEF  = 4096;
    localparam int NUM_BINS_DEF = 64;

    localparam int VLEN_W  = 13;
    localparam int IDX_W   = 12;
    localparam int VAL_W   = 16;
    localparam int GRP_W   = 6;
    localparam int LEAK_W  = 16;
    localparam int SUM_W   = 36;
    localparam int MAX_W   = 16;
    localparam int CNT_W   = 20;
    localparam int ACC_W   = 48;
    localparam int HALF_W  = 24;
    localparam int SQR_W   = 96;
    localparam int CAND_W  = 80;
    localparam int QN_W    = 64;
    localparam int BIN_W   = SUM_W + MAX_W + CNT_W;

    localparam logic [VLEN_W-1:0] VLEN_RESET = 13'd4096;
    localparam logic [VLEN_W-1:0] POS_LIMIT  = 13'd8191;
    localparam logic [SUM_W-1:0]  SUM_LIMIT  = '1;
    localparam logic [CNT_W-1:0]  CNT_LIMIT  = '1;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SAMPLE = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    localparam logic RESP_ROW  = 1'b0;
    localparam logic RESP_STAT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_CHECK,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_ROOT_ADD,
        ST_ROOT_CMP,
        ST_BIN_RD,
        ST_ROW_OUT,
        ST_STAT_RD,
        ST_STAT_OUT
    } prs_state_t;

    typedef struct packed {
        logic in_ready;
        logic dir_wr;
        logic dir_rd;
        logic mac_mul;
        logic mac_acc;
        logic leak_clr;
        logic sq0;
        logic sq1;
        logic sq2;
        logic sq3;
        logic root_add;
        logic root_cmp;
        logic bin_rd;
        logic row_done;
        logic stat_out;
    } prs_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       row_last;
        logic       row_bad;
        logic       norm_zero;
        logic       bit_zero;
        logic       out_busy;
    } prs_status_t;

endpackage

FILE: hdl/prs_ctrl.sv
// Controller state machine that sequences the datapath for each input beat.
module prs_ctrl import prs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  prs_status_t sts,
    output prs_cmd_t    cmd
);

    prs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                case (sts.req_type)
                    REQ_SAMPLE: state_next = ST_MAC_MUL;
                    REQ_READ:   state_next = ST_STAT_RD;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_MAC_MUL: state_next = ST_MAC_ACC;
            ST_MAC_ACC: state_next = sts.row_last ? ST_CHECK : ST_IDLE;
            ST_CHECK: begin
                state_next = (sts.row_bad || sts.norm_zero) ? ST_BIN_RD : ST_SQ0;
            end
            ST_SQ0:      state_next = ST_SQ1;
            ST_SQ1:      state_next = ST_SQ2;
            ST_SQ2:      state_next = ST_SQ3;
            ST_SQ3:      state_next = ST_ROOT_ADD;
            ST_ROOT_ADD: state_next = ST_ROOT_CMP;
            ST_ROOT_CMP: state_next = sts.bit_zero ? ST_BIN_RD : ST_ROOT_ADD;
            ST_BIN_RD:   state_next = ST_ROW_OUT;
            ST_ROW_OUT: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            ST_STAT_RD:  state_next = ST_STAT_OUT;
            ST_STAT_OUT: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:     cmd.in_ready = 1'b1;
            ST_DECODE: begin
                cmd.dir_wr = (sts.req_type == REQ_LOAD);
                cmd.dir_rd = (sts.req_type == REQ_SAMPLE);
            end
            ST_MAC_MUL:  cmd.mac_mul  = 1'b1;
            ST_MAC_ACC:  cmd.mac_acc  = 1'b1;
            ST_CHECK:    cmd.leak_clr = 1'b1;
            ST_SQ0:      cmd.sq0      = 1'b1;
            ST_SQ1:      cmd.sq1      = 1'b1;
            ST_SQ2:      cmd.sq2      = 1'b1;
            ST_SQ3:      cmd.sq3      = 1'b1;
            ST_ROOT_ADD: cmd.root_add = 1'b1;
            ST_ROOT_CMP: cmd.root_cmp = 1'b1;
            ST_BIN_RD:   cmd.bin_rd   = 1'b1;
            ST_ROW_OUT:  cmd.row_done = !sts.out_busy;
            ST_STAT_RD:  cmd.bin_rd   = 1'b1;
            ST_STAT_OUT: cmd.stat_out = !sts.out_busy;
            default:     cmd = '0;
        endcase
    end

endmodule

FILE: hdl/prs_dp.sv
// Datapath: direction memory, accumulators, root search, bin memory, output register.
module prs_dp import prs_pkg::*; #(
    parameter int VEC_MAX  = VEC_MAX_DEF,
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [VLEN_W-1:0]   vec_len,
    input  prs_cmd_t            cmd,
    output prs_status_t         sts,
    input  logic [1:0]          in_req_type,
    input  logic [IDX_W-1:0]    in_elem_index,
    input  logic [VAL_W-1:0]    in_value,
    input  logic [GRP_W-1:0]    in_group,
    input  logic                in_row_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_resp_kind,
    output logic                out_status,
    output logic [LEAK_W-1:0]   out_leak,
    output logic [SUM_W-1:0]    out_group_sum,
    output logic [MAX_W-1:0]    out_group_max,
    output logic [CNT_W-1:0]    out_group_count
);

    localparam int AW = $clog2(VEC_MAX);
    localparam int BW = $clog2(NUM_BINS);

    // Captured input beat.
    logic [1:0]       req_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [VAL_W-1:0] val_reg;
    logic [GRP_W-1:0] grp_reg;
    logic             last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.in_ready) begin
            req_reg  <= in_req_type;
            idx_reg  <= in_elem_index;
            val_reg  <= in_value;
            grp_reg  <= in_group;
            last_reg <= in_row_last;
        end
    end

    // Direction memory.
    logic [VAL_W-1:0]    dir_mem [VEC_MAX];
    logic [VAL_W-1:0]    dir_q_reg;
    logic [IDX_W+AW-1:0] widx_ext;
    logic [AW-1:0]       waddr;
    logic                widx_ok;
    logic [VLEN_W-1:0]   pos_reg;
    logic [VLEN_W+AW-1:0] pos_ext;
    logic [AW-1:0]       raddr;
    logic                pos_ok;

    assign widx_ext = (IDX_W + AW)'(idx_reg);
    assign waddr    = widx_ext[AW-1:0];
    assign widx_ok  = (32'(idx_reg) < VEC_MAX);
    assign pos_ext  = (VLEN_W + AW)'(pos_reg);
    assign raddr    = pos_ext[AW-1:0];
    assign pos_ok   = (32'(pos_reg) < VEC_MAX);

    always_ff @(posedge aclk) begin
        if (cmd.dir_wr && widx_ok) begin
            dir_mem[waddr] <= val_reg;
        end
        if (cmd.dir_rd && pos_ok) begin
            dir_q_reg <= dir_mem[raddr];
        end
    end

    // Multiply-accumulate.
    logic signed [2*VAL_W-1:0] prod_reg;
    logic signed [2*VAL_W-1:0] sq_reg;
    logic signed [ACC_W-1:0]   dot_reg;
    logic [ACC_W-1:0]          norm_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mac_mul) begin
            prod_reg <= $signed(val_reg) * $signed(dir_q_reg);
            sq_reg   <= $signed(val_reg) * $signed(val_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg  <= '0;
            norm_reg <= '0;
            pos_reg  <= '0;
        end else if (cmd.row_done) begin
            dot_reg  <= '0;
            norm_reg <= '0;
            pos_reg  <= '0;
        end else if (cmd.mac_acc) begin
            if (pos_ok) begin
                dot_reg  <= dot_reg + ACC_W'(prod_reg);
                norm_reg <= norm_reg + ACC_W'($unsigned(sq_reg));
            end
            if (pos_reg < POS_LIMIT) begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    logic row_bad;
    assign row_bad = (pos_reg != vec_len) || (32'(pos_reg) > VEC_MAX) || (pos_reg >= POS_LIMIT);

    // Square of 2|dot| from three half-width products.
    logic [ACC_W-1:0]    mag;
    logic [ACC_W-1:0]    mag2;
    logic [HALF_W-1:0]   mul_a, mul_b;
    logic [2*HALF_W-1:0] hp_reg;
    logic [SQR_W-1:0]    d_reg;

    assign mag  = dot_reg[ACC_W-1] ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);
    assign mag2 = {mag[ACC_W-2:0], 1'b0};

    always_comb begin
        mul_a = mag2[ACC_W-1:HALF_W];
        mul_b = mag2[ACC_W-1:HALF_W];
        if (cmd.sq1) begin
            mul_b = mag2[HALF_W-1:0];
        end else if (cmd.sq2) begin
            mul_a = mag2[HALF_W-1:0];
            mul_b = mag2[HALF_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sq0 || cmd.sq1 || cmd.sq2) begin
            hp_reg <= mul_a * mul_b;
        end
        if (cmd.sq1) begin
            d_reg <= SQR_W'(hp_reg) << (2 * HALF_W);
        end else if (cmd.sq2) begin
            d_reg <= d_reg + (SQR_W'(hp_reg) << (HALF_W + 1));
        end else if (cmd.sq3) begin
            d_reg <= d_reg + SQR_W'(hp_reg);
        end
    end

    // Bit-by-bit search for the largest q with q*q*norm <= (2|dot|)^2.
    logic [CAND_W-1:0] p_reg;
    logic [CAND_W-1:0] cand_reg;
    logic [QN_W-1:0]   qn_reg;
    logic [LEAK_W-1:0] leak_reg;
    logic [3:0]        bit_reg;

    always_ff @(posedge aclk) begin
        if (cmd.leak_clr) begin
            leak_reg <= '0;
        end
        if (cmd.sq0) begin
            p_reg    <= '0;
            qn_reg   <= '0;
            leak_reg <= '0;
            bit_reg  <= 4'd15;
        end
        if (cmd.root_add) begin
            cand_reg <= p_reg
                      + (CAND_W'(qn_reg) << (bit_reg + 1'b1))
                      + (CAND_W'(norm_reg) << {bit_reg, 1'b0});
        end
        if (cmd.root_cmp) begin
            if (SQR_W'(cand_reg) <= d_reg) begin
                p_reg    <= cand_reg;
                qn_reg   <= qn_reg + (QN_W'(norm_reg) << bit_reg);
                leak_reg <= leak_reg | (LEAK_W'(1) << bit_reg);
            end
            bit_reg <= bit_reg - 1'b1;
        end
    end

    // Group statistics memory with one valid bit per entry.
    logic [BIN_W-1:0]       bin_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    bin_vld_reg;
    logic [BIN_W-1:0]       bin_q_reg;
    logic                   bin_hit_reg;
    logic [GRP_W+BW-1:0]    grp_ext;
    logic [BW-1:0]          baddr;
    logic                   grp_ok;
    logic [SUM_W-1:0]       old_sum, new_sum;
    logic [MAX_W-1:0]       old_max, new_max;
    logic [CNT_W-1:0]       old_cnt, new_cnt;
    logic [SUM_W:0]         sum_wide;
    logic                   bin_upd;

    assign grp_ext = (GRP_W + BW)'(grp_reg);
    assign baddr   = grp_ext[BW-1:0];
    assign grp_ok  = (32'(grp_reg) < NUM_BINS);

    assign old_sum  = bin_hit_reg ? bin_q_reg[BIN_W-1 -: SUM_W] : '0;
    assign old_max  = bin_hit_reg ? bin_q_reg[CNT_W +: MAX_W] : '0;
    assign old_cnt  = bin_hit_reg ? bin_q_reg[CNT_W-1:0] : '0;
    assign sum_wide = {1'b0, old_sum} + (SUM_W + 1)'(leak_reg);
    assign new_sum  = sum_wide[SUM_W] ? SUM_LIMIT : sum_wide[SUM_W-1:0];
    assign new_max  = (leak_reg > old_max) ? leak_reg : old_max;
    assign new_cnt  = (old_cnt < CNT_LIMIT) ? old_cnt + 1'b1 : old_cnt;
    assign bin_upd  = cmd.row_done && !row_bad && grp_ok;

    always_ff @(posedge aclk) begin
        if (cmd.bin_rd) begin
            bin_q_reg <= bin_mem[baddr];
        end
        if (bin_upd) begin
            bin_mem[baddr] <= {new_sum, new_max, new_cnt};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
            bin_hit_reg <= 1'b0;
        end else begin
            if (cmd.bin_rd) begin
                bin_hit_reg <= grp_ok && bin_vld_reg[baddr];
            end
            if (bin_upd) begin
                bin_vld_reg[baddr] <= 1'b1;
            end
        end
    end

    // Output register.
    logic             out_valid_reg;
    logic             out_kind_reg;
    logic             out_status_reg;
    logic [LEAK_W-1:0] out_leak_reg;
    logic [SUM_W-1:0] out_sum_reg;
    logic [MAX_W-1:0] out_max_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.row_done || cmd.stat_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_done) begin
            out_kind_reg   <= RESP_ROW;
            out_status_reg <= row_bad;
            out_leak_reg   <= row_bad ? '0 : leak_reg;
            out_sum_reg    <= '0;
            out_max_reg    <= '0;
            out_cnt_reg    <= '0;
        end else if (cmd.stat_out) begin
            out_kind_reg   <= RESP_STAT;
            out_status_reg <= 1'b0;
            out_leak_reg   <= '0;
            out_sum_reg    <= old_sum;
            out_max_reg    <= old_max;
            out_cnt_reg    <= old_cnt;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_resp_kind   = out_kind_reg;
    assign out_status      = out_status_reg;
    assign out_leak        = out_leak_reg;
    assign out_group_sum   = out_sum_reg;
    assign out_group_max   = out_max_reg;
    assign out_group_count = out_cnt_reg;

    assign sts.req_type  = req_reg;
    assign sts.row_last  = last_reg;
    assign sts.row_bad   = row_bad;
    assign sts.norm_zero = (norm_reg == '0);
    assign sts.bit_zero  = (bit_reg == 4'd0);
    assign sts.out_busy  = out_valid_reg && !out_ready;

endmodule

FILE: hdl/projection_ratio_stats_core.sv
// Top level: normalized dot product of sample rows with per-group leak statistics.
// One beat at a time: a direction load is written in decode, a mid-row sample is multiplied
// and accumulated, a statistics read does a bin read and output, and a row end runs the check,
// square and root search (skipped for flagged or zero-norm rows), bin read and output.
// A result still waiting at the output holds back the next row end or readout, and the input.
// Synchronous active-low reset clears accumulators, bin valid bits and output; vec_len = 4096.
`include "projection_ratio_stats_core_defines.svh"
module projection_ratio_stats_core import prs_pkg::*; #(
    parameter int VEC_MAX  = VEC_MAX_DEF,
    parameter int NUM_BINS = NUM_BINS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // elem_index[11:0], value[27:12], group[33:28], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    input  logic        s_tlast,   // row_last
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // status[0], leak[16:1], group_sum[52:17],
                                   // group_max[68:53], group_count[88:69], zero pad
    output logic [0:0]  m_tuser,   // resp_kind[0]
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The only register, vec_len, lives at byte address zero.
    logic [VLEN_W-1:0] vec_len_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_len_reg <= VLEN_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == 3'd0)) begin
            vec_len_reg <= pwdata[VLEN_W-1:0];
        end
    end

    assign prdata = (paddr == 3'd0) ? 32'(vec_len_reg) : '0;

    // The controller and datapath talk only through the command and status structs.
    prs_cmd_t    cmd;
    prs_status_t sts;

    prs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    logic              out_status;
    logic [LEAK_W-1:0] out_leak;
    logic [SUM_W-1:0]  out_sum;
    logic [MAX_W-1:0]  out_max;
    logic [CNT_W-1:0]  out_cnt;

    prs_dp #(
        .VEC_MAX  (VEC_MAX),
        .NUM_BINS (NUM_BINS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .vec_len         (vec_len_reg),
        .cmd             (cmd),
        .sts             (sts),
        .in_req_type     (s_tuser),
        .in_elem_index   (s_tdata[11:0]),
        .in_value        (s_tdata[27:12]),
        .in_group        (s_tdata[33:28]),
        .in_row_last     (s_tlast),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_resp_kind   (m_tuser[0]),
        .out_status      (out_status),
        .out_leak        (out_leak),
        .out_group_sum   (out_sum),
        .out_group_max   (out_max),
        .out_group_count (out_cnt)
    );

    // The input is taken only while the controller waits for a new beat.
    assign s_tready = cmd.in_ready;

    assign m_tdata = {7'd0, out_cnt, out_max, out_sum, out_leak, out_status};

    // After an input beat is taken, the block works on it before taking another.
    `PRS_ASSERT_NEXT(a_one_beat_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // A statistics readout carries no status and no leak.
    `PRS_ASSERT_NOW(a_stat_fields_clear, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[16:0] == 17'd0)
    // A flagged row reports zero leak and no group statistics.
    `PRS_ASSERT_NOW(a_bad_row_zero, aclk, aresetn, m_tvalid && !m_tuser[0] && m_tdata[0], m_tdata[88:1] == 88'd0)

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the projection ratio statistics core.
module tb import prs_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIR_DEPTH  = 4096;
    localparam int DIR_FILL   = 20;      // covers every row position this run reaches
    localparam int BIN_COUNT  = 64;
    localparam int IDLE_LIMIT = 20000;   // cycles without any beat before giving up
    localparam int DRAIN_WAIT = 60;      // longer than a row end plus output hold
    localparam logic [2:0] ADDR_VEC_LEN = 3'd0;
    localparam logic [1:0] REQ_NONE     = 2'd3;

    // One result beat as the block should present it.
    typedef struct {
        logic        kind;
        logic        status;
        logic [15:0] leak;
        logic [35:0] sum;
        logic [15:0] peak;
        logic [19:0] count;
    } stat_beat_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // elem_index[11:0], value[27:12], group[33:28], zero pad
    logic [1:0]  s_tuser;    // req_type[1:0]
    logic        s_tlast;    // row_last
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;    // status[0], leak[16:1], group_sum[52:17],
                             // group_max[68:53], group_count[88:69], zero pad
    logic [0:0]  m_tuser;    // resp_kind[0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    projection_ratio_stats_core dut (.*);

    // Predictor state: a private copy of everything the block remembers.
    logic signed [15:0] dir_mem [DIR_DEPTH];
    longint             dot_sum;
    longint             norm_sum;
    int unsigned        row_pos;
    logic [12:0]        row_len_cfg;
    logic [35:0]        bin_sum   [BIN_COUNT];
    logic [15:0]        bin_peak  [BIN_COUNT];
    logic [19:0]        bin_count [BIN_COUNT];

    stat_beat_t  pending_beats[$];
    int          mismatches;
    int          idle_cycles;
    int          src_idle_pct;
    int          snk_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Leak in Q16.0: largest q with q*q*norm <= (2*|dot|)^2, so it saturates
    // at 65535 by construction, and is zero when the norm is zero.
    function automatic logic [15:0] leak_of_row(longint dot, longint norm);
        logic [127:0] mag;
        logic [127:0] rhs;
        logic [127:0] cand;
        logic [15:0]  q;
        if (norm <= 0) begin
            return 16'd0;
        end
        mag = (dot < 0) ? 128'(-dot) : 128'(dot);
        mag = mag * 2;
        rhs = mag * mag;
        q = '0;
        for (int b = 15; b >= 0; b--) begin
            cand = 128'(q) | (128'd1 << b);
            if (cand * cand * 128'(norm) <= rhs) begin
                q = cand[15:0];
            end
        end
        return q;
    endfunction

    // Applies one accepted input beat to the predictor and queues its result.
    task automatic predict_beat(logic [1:0] req, logic [11:0] idx, logic signed [15:0] val,
                                logic [5:0] grp, logic last);
        stat_beat_t exp_beat;
        logic       bad;
        logic [36:0] total;
        exp_beat = '{kind: RESP_ROW, status: 1'b0, leak: '0, sum: '0, peak: '0, count: '0};
        case (req)
            REQ_LOAD: begin
                dir_mem[idx] = val;
            end
            REQ_READ: begin
                exp_beat.kind  = RESP_STAT;
                exp_beat.sum   = bin_sum[grp];
                exp_beat.peak  = bin_peak[grp];
                exp_beat.count = bin_count[grp];
                pending_beats.push_back(exp_beat);
            end
            REQ_SAMPLE: begin
                if (row_pos < DIR_DEPTH) begin
                    dot_sum  += longint'(val) * longint'(dir_mem[row_pos]);
                    norm_sum += longint'(val) * longint'(val);
                end
                if (row_pos < 8191) begin
                    row_pos++;
                end
                if (last) begin
                    bad = (row_pos != row_len_cfg) || (row_pos > DIR_DEPTH) || (row_pos >= 8191);
                    exp_beat.status = bad;
                    exp_beat.leak   = bad ? 16'd0 : leak_of_row(dot_sum, norm_sum);
                    if (!bad) begin
                        total = {1'b0, bin_sum[grp]} + 37'(exp_beat.leak);
                        bin_sum[grp] = total[36] ? SUM_LIMIT : total[35:0];
                        if (exp_beat.leak > bin_peak[grp]) begin
                            bin_peak[grp] = exp_beat.leak;
                        end
                        if (bin_count[grp] != CNT_LIMIT) begin
                            bin_count[grp]++;
                        end
                    end
                    dot_sum  = 0;
                    norm_sum = 0;
                    row_pos  = 0;
                    pending_beats.push_back(exp_beat);
                end
            end
            default: begin
            end
        endcase
    endtask

    // Sends one beat, waits for it to be taken, then maybe idles the sender.
    task automatic send_beat(logic [1:0] req, logic [11:0] idx, logic signed [15:0] val,
                             logic [5:0] grp, logic last);
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tlast  <= last;
        s_tdata  <= {6'd0, grp, val, idx};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predict_beat(req, idx, val, grp, last);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct) begin
                @(posedge aclk);
            end
        end
    endtask

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(0, 64)) - 16'sd32;
            1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // One row of samples; reads and loads may be slipped in between elements.
    task automatic send_row(int len, logic [5:0] grp, bit interleave);
        for (int i = 0; i < len; i++) begin
            if (interleave && $urandom_range(19) == 0) begin
                if ($urandom_range(1)) begin
                    send_beat(REQ_READ, 12'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
                end else begin
                    send_beat(REQ_LOAD, 12'($urandom), pick_sample(), 6'($urandom),
                              1'($urandom));
                end
            end
            send_beat(REQ_SAMPLE, 12'($urandom), pick_sample(), grp, i == len - 1);
        end
    endtask

    // Waits until every result is in, then lets trailing work finish.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Register write: setup cycle then access cycle; only called when drained.
    task automatic write_vec_len(logic [12:0] len);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_VEC_LEN;
        pwdata  <= 32'(len);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        row_len_cfg = len;
        @(posedge aclk);
    endtask

    // Fills the direction entries that rows in this run reach, so none reads an unwritten one.
    task automatic test_direction_fill();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        for (int i = 0; i < DIR_FILL; i++) begin
            send_beat(REQ_LOAD, 12'(i), (i % 2) ? 16'sh7FFF : 16'sh8000, 6'd0, 1'b0);
        end
        drain();
    endtask

    // Short directed list: field extremes, every request kind, special cases.
    task automatic test_directed_edges();
        write_vec_len(13'd4);
        send_beat(REQ_READ, 12'hFFF, 16'sh7FFF, 6'd63, 1'b1);       // empty bin
        for (int i = 0; i < 4; i++) begin                           // zero norm
            send_beat(REQ_SAMPLE, 12'd0, 16'sd0, 6'd1, i == 3);
        end
        for (int i = 0; i < 4; i++) begin                           // saturated leak
            send_beat(REQ_SAMPLE, 12'hFFF, (i % 2) ? 16'sh0100 : 16'shFF00, 6'd63, i == 3);
        end
        send_beat(REQ_NONE, 12'hFFF, 16'shFFFF, 6'd63, 1'b1);       // unused request
        send_beat(REQ_SAMPLE, 12'd0, 16'sh8000, 6'd2, 1'b1);        // too short
        send_beat(REQ_SAMPLE, 12'd0, 16'sh7FFF, 6'd2, 1'b0);
        send_beat(REQ_READ, 12'd0, 16'sd0, 6'd63, 1'b0);            // read mid-row
        send_beat(REQ_LOAD, 12'd1, 16'sh4000, 6'd0, 1'b0);          // load mid-row
        send_beat(REQ_SAMPLE, 12'd0, 16'sh0001, 6'd2, 1'b0);
        send_beat(REQ_SAMPLE, 12'd0, 16'shFF00, 6'd2, 1'b0);
        send_beat(REQ_SAMPLE, 12'd0, 16'sh0100, 6'd2, 1'b1);
        send_beat(REQ_READ, 12'd0, 16'sd0, 6'd2, 1'b0);
        send_beat(REQ_READ, 12'd0, 16'sd0, 6'd1, 1'b0);
        drain();
    endtask

    // Shortest rows, then a longer length with a row one element too long.
    task automatic test_length_extremes();
        write_vec_len(13'd1);
        send_row(1, 6'd5, 1'b0);
        send_row(2, 6'd5, 1'b0);
        drain();
        write_vec_len(13'd16);
        send_row(16, 6'd6, 1'b0);
        send_row(17, 6'd6, 1'b0);
        send_beat(REQ_READ, 12'd0, 16'sd0, 6'd6, 1'b0);
        drain();
    endtask

    // Mostly well-formed rows, with broken rows and noise mixed in.
    task automatic test_random_traffic(int beats, int idle_pct, int stall_pct);
        int start;
        int len;
        int pick;
        bit drained;
        start   = 0;
        drained = 1'b0;
        write_vec_len(13'($urandom_range(1, 12)));
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        while (start < beats) begin
            pick = $urandom_range(99);
            if (pick < 6) begin
                send_beat(REQ_LOAD, 12'($urandom), pick_sample(), 6'($urandom), 1'($urandom));
                start++;
            end else if (pick < 14) begin
                send_beat(REQ_READ, 12'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
                start++;
            end else if (pick < 16) begin
                send_beat(REQ_NONE, 12'($urandom), 16'($urandom), 6'($urandom), 1'($urandom));
            end else if (pick < 24) begin
                len = int'(row_len_cfg) + $urandom_range(1, 3) * ($urandom_range(1) ? 1 : -1);
                len = (len < 1) ? int'(row_len_cfg) + 1 : len;
                send_row(len, 6'($urandom), 1'b1);
                start += len;
            end else begin
                send_row(row_len_cfg, 6'($urandom_range(0, 7)), 1'b1);
                start += row_len_cfg;
            end
            // Once per phase the sender holds off until the block is empty.
            if (!drained && start > beats / 2) begin
                drain();
                drained = 1'b1;
            end
        end
        drain();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
    endtask

    // Receiver back-pressure.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Compares every result beat with the oldest expectation.
    always @(posedge aclk) begin
        stat_beat_t exp_beat;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: tuser=%0h tdata=%h", m_tuser, m_tdata);
                end
            end else begin
                exp_beat = pending_beats.pop_front();
                if (m_tuser[0] !== exp_beat.kind || m_tdata[0] !== exp_beat.status ||
                    m_tdata[16:1] !== exp_beat.leak || m_tdata[52:17] !== exp_beat.sum ||
                    m_tdata[68:53] !== exp_beat.peak || m_tdata[88:69] !== exp_beat.count ||
                    m_tdata[95:89] !== '0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected kind=%0d status=%0d leak=%0d",
                                 exp_beat.kind, exp_beat.status, exp_beat.leak,
                                 " sum=%0d max=%0d count=%0d",
                                 exp_beat.sum, exp_beat.peak, exp_beat.count);
                        $display("                 actual   kind=%0d status=%0d leak=%0d",
                                 m_tuser[0], m_tdata[0], m_tdata[16:1],
                                 " sum=%0d max=%0d count=%0d pad=%0h",
                                 m_tdata[52:17], m_tdata[68:53], m_tdata[88:69],
                                 m_tdata[95:89]);
                    end
                end
            end
        end
    end

    // Watchdog: a long stretch with no beat on either side means a hang.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("projection_ratio_stats_core verification failed");
            $finish;
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        dot_sum     = 0;
        norm_sum    = 0;
        row_pos     = 0;
        row_len_cfg = VLEN_RESET;
        for (int i = 0; i < DIR_DEPTH; i++) begin
            dir_mem[i] = '0;
        end
        for (int g = 0; g < BIN_COUNT; g++) begin
            bin_sum[g]   = '0;
            bin_peak[g]  = '0;
            bin_count[g] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_direction_fill();
        test_directed_edges();
        test_length_extremes();
        test_random_traffic(175, 0, 0);
        test_random_traffic(175, 79, 0);
        test_random_traffic(175, 0, 79);
        test_random_traffic(175, 28, 28);

        if (mismatches == 0 && pending_beats.size() == 0) begin
            $display("projection_ratio_stats_core verification clean");
        end else begin
            $display("projection_ratio_stats_core verification failed");
        end
        $finish;
    end
endmodule
